// ----- sv/bdf_pkg.sv -----
// Shared types and constants for the broadcast duplicate filter.
`default_nettype none
package bdf_pkg;

  localparam int NODE_COUNT_DEF = 256;
  localparam int SEQ_W = 32;

  localparam logic [1:0] OUTCOME_FIRST = 2'd0;
  localparam logic [1:0] OUTCOME_NEWER = 2'd1;
  localparam logic [1:0] OUTCOME_STALE = 2'd2;

  typedef struct packed {
    logic [7:0]              node_id;
    logic signed [SEQ_W-1:0] sequence_req;
  } req_t;

  typedef struct packed {
    logic       sendable;
    logic [1:0] outcome;
  } rsp_t;

  typedef struct packed {
    logic                    seen;
    logic signed [SEQ_W-1:0] seq;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ----- sv/bdf_ram.sv -----
// Generic single-write, single-read memory with registered read data.
`default_nettype none
module bdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/bdf_update.sv -----
// Compare stage: forwards the previous write, decides the outcome and writes the entry back.
`default_nettype none
module bdf_update #(
  parameter int NODE_COUNT = bdf_pkg::NODE_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          valid,
  input  wire logic                          in_range,
  input  wire logic [$clog2(NODE_COUNT)-1:0] addr,
  input  wire logic [bdf_pkg::SEQ_W-1:0]     seq,
  input  wire bdf_pkg::entry_t               rd_entry,
  output logic                               we,
  output logic [$clog2(NODE_COUNT)-1:0]      waddr,
  output bdf_pkg::entry_t                    wdata,
  output logic                               done,
  output bdf_pkg::rsp_t                      rsp
);
  import bdf_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);

  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  entry_t        fwd_data;
  entry_t        cur;
  rsp_t          rsp_next;

  // The memory returns stale data when the previous transaction wrote the same entry.
  always_comb begin
    if (fwd_valid && fwd_addr == addr) begin
      cur = fwd_data;
    end else begin
      cur = rd_entry;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = addr;
    wdata.seen = 1'b1;
    wdata.seq = seq;
    rsp_next.sendable = 1'b0;
    rsp_next.outcome = OUTCOME_STALE;
    if (valid && in_range) begin
      if (!cur.seen) begin
        we = 1'b1;
        rsp_next.sendable = 1'b1;
        rsp_next.outcome = OUTCOME_FIRST;
      end else if ($signed(cur.seq) < $signed(seq)) begin
        we = 1'b1;
        rsp_next.sendable = 1'b1;
        rsp_next.outcome = OUTCOME_NEWER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      fwd_valid <= we;
      done <= valid;
    end
    fwd_addr <= waddr;
    fwd_data <= wdata;
    rsp <= rsp_next;
  end

endmodule
`default_nettype wire

// ----- sv/broadcast_duplicate_filter_top.sv -----
// Top level of the broadcast duplicate filter.
//
// Each transaction carries a source node id and a signed sequence number. A
// transaction is accepted at a rising edge with start high and busy low. The
// block answers every transaction with one result: sendable and outcome
// (first message from the node, newer sequence stored, or not newer). A node
// id at or beyond NODE_COUNT is answered as not newer and changes nothing.
//
// Results appear on rsp with done high for exactly one cycle, once the request has
// passed the s1 registers and the registered done and rsp of the compare stage, and
// are taken at the edge that ends that cycle. The receiver cannot stall, so none are held.
// One transaction can be accepted in every cycle while busy is low; the per-node
// table is one memory read stage followed by a compare and write-back stage,
// with the last write forwarded when consecutive transactions hit one node.
//
// After reset the table is swept once to clear every seen flag, one entry a
// cycle. Busy is high during that sweep and low at all other times.
`default_nettype none
module broadcast_duplicate_filter_top #(
  parameter int NODE_COUNT = bdf_pkg::NODE_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire bdf_pkg::req_t req,
  output logic               done,
  output bdf_pkg::rsp_t      rsp
);
  import bdf_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);

  logic                clearing;
  logic [AW-1:0]       clr_addr;
  logic                s1_valid;
  logic                s1_in_range;
  logic [AW-1:0]       s1_addr;
  logic [SEQ_W-1:0]    s1_seq;
  logic                accept;
  logic [AW-1:0]       raddr;
  logic [ENTRY_W-1:0]  rdata;
  logic                upd_we;
  logic [AW-1:0]       upd_waddr;
  entry_t              upd_wdata;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;

  assign busy = clearing;
  assign accept = start && !clearing;
  assign raddr = AW'(req.node_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (clearing) begin
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + AW'(1);
        end
      end
    end
    s1_addr <= raddr;
    s1_in_range <= (32'(req.node_id) < 32'(NODE_COUNT));
    s1_seq <= req.sequence_req;
  end

  always_comb begin
    if (clearing) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we = upd_we;
      ram_waddr = upd_waddr;
      ram_wdata = upd_wdata;
    end
  end

  bdf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NODE_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  bdf_update #(
    .NODE_COUNT(NODE_COUNT)
  ) u_update (
    .clk     (clk),
    .rst     (rst),
    .valid   (s1_valid),
    .in_range(s1_in_range),
    .addr    (s1_addr),
    .seq     (s1_seq),
    .rd_entry(entry_t'(rdata)),
    .we      (upd_we),
    .waddr   (upd_waddr),
    .wdata   (upd_wdata),
    .done    (done),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the broadcast duplicate filter top level.
`timescale 1ns / 100ps
module tb;
  import bdf_pkg::*;

  localparam int NODES = NODE_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1600;

  class dup_filter_scoreboard;
    bit                    seen [NODES];
    logic signed [SEQ_W-1:0] last_seq [NODES];
    rsp_t                  verdict_q [$];
    int                    errors;

    function new();
      for (int n = 0; n < NODES; n++) begin
        seen[n] = 1'b0;
        last_seq[n] = '0;
      end
      errors = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      e.sendable = 1'b0;
      e.outcome = OUTCOME_STALE;
      if (int'(r.node_id) < NODES) begin
        if (!seen[r.node_id]) begin
          seen[r.node_id] = 1'b1;
          last_seq[r.node_id] = r.sequence_req;
          e.sendable = 1'b1;
          e.outcome = OUTCOME_FIRST;
        end else if ($signed(r.sequence_req) > $signed(last_seq[r.node_id])) begin
          last_seq[r.node_id] = r.sequence_req;
          e.sendable = 1'b1;
          e.outcome = OUTCOME_NEWER;
        end
      end
      verdict_q.push_back(e);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_response(rsp_t got);
      rsp_t e;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result sendable=%0b outcome=%0d",
                                  got.sendable, got.outcome));
      end else begin
        e = verdict_q.pop_front();
        if (got.sendable !== e.sendable)
          report_mismatch($sformatf("sendable got %0b want %0b", got.sendable, e.sendable));
        if (got.outcome !== e.outcome)
          report_mismatch($sformatf("outcome got %0d want %0d", got.outcome, e.outcome));
      end
    endtask

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  dup_filter_scoreboard sb;
  int idle_cycles;
  logic signed [SEQ_W-1:0] last_sent [256];

  broadcast_duplicate_filter_top #(.NODE_COUNT(NODES)) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(req);
      if (done) sb.check_response(rsp);
      if ((start && !busy) || done) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  task send_item(input logic [7:0] node, input logic signed [SEQ_W-1:0] seq,
                 input bit idle_ok);
    if (idle_ok && $urandom_range(0, 99) < 33) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start = 1'b1;
    req.node_id = node;
    req.sequence_req = seq;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task wait_for_drain();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int mode;
    int step;
    logic [7:0] node;
    logic signed [SEQ_W-1:0] seq;

    sb = new();
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    for (int n = 0; n < 256; n++) last_sent[n] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Extremes, equal sequence, sign wrap, and back-to-back hits on one node.
    send_item(8'd0,   32'sh8000_0000, 1'b0);
    send_item(8'd0,   32'sh7FFF_FFFF, 1'b0);
    send_item(8'd0,   32'sh7FFF_FFFF, 1'b0);
    send_item(8'd0,   32'sh8000_0000, 1'b0);
    send_item(8'd0,   32'sh0000_0000, 1'b0);
    send_item(8'd255, 32'sh7FFF_FFFF, 1'b0);
    send_item(8'd255, 32'sh8000_0000, 1'b0);
    send_item(8'd128, 32'sh0000_0000, 1'b0);
    send_item(8'd128, 32'shFFFF_FFFF, 1'b0);
    send_item(8'd128, 32'sh0000_0001, 1'b0);
    send_item(8'd7,   32'sd5, 1'b0);
    send_item(8'd7,   32'sd6, 1'b0);
    send_item(8'd7,   32'sd6, 1'b0);
    send_item(8'd7,   32'sd7, 1'b0);
    send_item(8'd7,   32'sd4, 1'b0);
    send_item(8'd7,   32'sd8, 1'b0);
    send_item(8'd8,   32'sh5555_5555, 1'b0);
    send_item(8'd7,   32'sd9, 1'b0);
    send_item(8'd8,   32'shAAAA_AAAA, 1'b0);
    send_item(8'd8,   32'sh5555_5556, 1'b0);
    send_item(8'd8,   32'sh5555_5556, 1'b1);
    send_item(8'd7,   32'sd10, 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 1000) wait_for_drain();
      node = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      mode = $urandom_range(0, 99);
      if (mode < 60) begin
        step = int'($urandom_range(0, 4)) - 1;
        seq = last_sent[node] + step;
      end else if (mode < 85) begin
        seq = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0: seq = 32'sh8000_0000;
          1: seq = 32'sh7FFF_FFFF;
          2: seq = 32'sh0000_0000;
          default: seq = 32'shFFFF_FFFF;
        endcase
      end
      last_sent[node] = seq;
      send_item(node, seq, !(i >= 500 && i < 800));
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
